[rtl/core/cccd_pkg.sv]
// ----------------------------------------------------------------------------
// cccd_pkg
// Shared types, constants and the CRC-16 byte update for the command
// frame deframer.
// ----------------------------------------------------------------------------
package cccd_pkg;

   // Register file layout
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_START_BYTE = 2'd0,
      CSR_END_BYTE   = 2'd1,
      CSR_MAX_LENGTH = 2'd2
   } csr_index_type;

   localparam logic [7:0]  START_BYTE_RESET = 8'hAA;
   localparam logic [7:0]  END_BYTE_RESET   = 8'h55;
   localparam logic [15:0] MAX_LENGTH_RESET = 16'd256;

   // CRC-16, init 0xFFFF, poly 0x1021, MSB first
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h1021;

   // Queue between parser and result stage
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   typedef enum logic [3:0] {
      PH_IDLE  = 4'd0,
      PH_LEN_L = 4'd1,
      PH_LEN_H = 4'd2,
      PH_SEQ   = 4'd3,
      PH_CMD   = 4'd4,
      PH_DATA  = 4'd5,
      PH_CRC_L = 4'd6,
      PH_CRC_H = 4'd7,
      PH_END   = 4'd8
   } phase_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_BAD_END = 2'd1,
      STATUS_BAD_CRC = 2'd2
   } status_type;

   typedef enum logic {
      KIND_PAYLOAD = 1'b0,
      KIND_VERDICT = 1'b1
   } kind_type;

   // One classified request handed from parser to result stage
   typedef struct packed {
      kind_type    kind;
      logic [7:0]  payload_byte;
      logic [7:0]  frame_seq;
      logic [7:0]  frame_cmd;
      logic [15:0] frame_length;
      logic        end_ok;
      logic        crc_ok;
   } entry_type;

   // Update the running CRC with one byte (eight shift steps)
   function automatic logic [15:0] crc_feed(logic [15:0] crc, logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

endpackage

[rtl/core/cccd_front.sv]
// ----------------------------------------------------------------------------
// cccd_front
// Frame parser: holds configuration, tracks the frame phase, runs the CRC
// and pushes one classified entry per payload byte or closing byte.
// ----------------------------------------------------------------------------
module cccd_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [7:0]                          req_rx_byte,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [cccd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [cccd_pkg::CSR_DATA_W-1:0]     csr_data,
   input  logic                                queue_full,
   output logic                                push_valid,
   output cccd_pkg::entry_type                 push_entry
);

   logic [7:0]          start_byte_ff;
   logic [7:0]          end_byte_ff;
   logic [15:0]         max_length_ff;

   cccd_pkg::phase_type phase_ff, phase_in;
   logic [15:0]         length_ff, length_in;
   logic [7:0]          seq_ff, seq_in;
   logic [7:0]          cmd_ff, cmd_in;
   logic [15:0]         count_ff, count_in;
   logic [15:0]         rx_crc_ff, rx_crc_in;
   logic [15:0]         crc_ff, crc_in;

   logic                accept;
   logic [15:0]         crc_next;
   logic [15:0]         length_full;
   logic [15:0]         count_inc;

   assign req_ready   = !queue_full;
   assign csr_ready   = 1'b1;
   assign accept      = req_valid && req_ready;
   assign crc_next    = cccd_pkg::crc_feed(crc_ff, req_rx_byte);
   assign length_full = {req_rx_byte, length_ff[7:0]};
   assign count_inc   = count_ff + 16'd1;

   // Write configuration registers; ignore unknown indexes
   always_ff @(posedge clock) begin
      if (reset) begin
         start_byte_ff <= cccd_pkg::START_BYTE_RESET;
         end_byte_ff   <= cccd_pkg::END_BYTE_RESET;
         max_length_ff <= cccd_pkg::MAX_LENGTH_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            cccd_pkg::CSR_START_BYTE: start_byte_ff <= csr_data[7:0];
            cccd_pkg::CSR_END_BYTE:   end_byte_ff   <= csr_data[7:0];
            cccd_pkg::CSR_MAX_LENGTH: max_length_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         unique case (phase_ff)
            cccd_pkg::PH_LEN_L: phase_in = cccd_pkg::PH_LEN_H;
            cccd_pkg::PH_LEN_H: phase_in = (length_full > max_length_ff) ?
                                           cccd_pkg::PH_IDLE : cccd_pkg::PH_SEQ;
            cccd_pkg::PH_SEQ:   phase_in = cccd_pkg::PH_CMD;
            cccd_pkg::PH_CMD:   phase_in = (length_ff != 16'd0) ?
                                           cccd_pkg::PH_DATA : cccd_pkg::PH_CRC_L;
            cccd_pkg::PH_DATA:  phase_in = (count_inc >= length_ff) ?
                                           cccd_pkg::PH_CRC_L : cccd_pkg::PH_DATA;
            cccd_pkg::PH_CRC_L: phase_in = cccd_pkg::PH_CRC_H;
            cccd_pkg::PH_CRC_H: phase_in = cccd_pkg::PH_END;
            cccd_pkg::PH_END:   phase_in = cccd_pkg::PH_IDLE;
            default:            phase_in = (req_rx_byte == start_byte_ff) ?
                                           cccd_pkg::PH_LEN_L : cccd_pkg::PH_IDLE;
         endcase
      end
   end

   // Datapath updates and queue push per phase
   always_comb begin
      length_in  = length_ff;
      seq_in     = seq_ff;
      cmd_in     = cmd_ff;
      count_in   = count_ff;
      rx_crc_in  = rx_crc_ff;
      crc_in     = crc_ff;
      push_valid = 1'b0;
      push_entry.kind         = cccd_pkg::KIND_PAYLOAD;
      push_entry.payload_byte = 8'h00;
      push_entry.frame_seq    = seq_ff;
      push_entry.frame_cmd    = cmd_ff;
      push_entry.frame_length = length_ff;
      push_entry.end_ok       = (req_rx_byte == end_byte_ff);
      push_entry.crc_ok       = (crc_ff == rx_crc_ff);
      if (accept) begin
         unique case (phase_ff)
            cccd_pkg::PH_LEN_L: begin
               length_in = {8'h00, req_rx_byte};
               crc_in    = crc_next;
            end
            cccd_pkg::PH_LEN_H: begin
               length_in = length_full;
               crc_in    = crc_next;
            end
            cccd_pkg::PH_SEQ: begin
               seq_in = req_rx_byte;
               crc_in = crc_next;
            end
            cccd_pkg::PH_CMD: begin
               cmd_in   = req_rx_byte;
               crc_in   = crc_next;
               count_in = 16'd0;
            end
            cccd_pkg::PH_DATA: begin
               crc_in     = crc_next;
               count_in   = count_inc;
               push_valid = 1'b1;
               push_entry.payload_byte = req_rx_byte;
            end
            cccd_pkg::PH_CRC_L: begin
               rx_crc_in = {8'h00, req_rx_byte};
            end
            cccd_pkg::PH_CRC_H: begin
               rx_crc_in = {req_rx_byte, rx_crc_ff[7:0]};
            end
            cccd_pkg::PH_END: begin
               push_valid      = 1'b1;
               push_entry.kind = cccd_pkg::KIND_VERDICT;
            end
            default: begin
               if (req_rx_byte == start_byte_ff) begin
                  crc_in = cccd_pkg::CRC_INIT;
               end
            end
         endcase
      end
   end

   // Hold parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= cccd_pkg::PH_IDLE;
         length_ff <= 16'd0;
         seq_ff    <= 8'd0;
         cmd_ff    <= 8'd0;
         count_ff  <= 16'd0;
         rx_crc_ff <= 16'd0;
         crc_ff    <= cccd_pkg::CRC_INIT;
      end else begin
         phase_ff  <= phase_in;
         length_ff <= length_in;
         seq_ff    <= seq_in;
         cmd_ff    <= cmd_in;
         count_ff  <= count_in;
         rx_crc_ff <= rx_crc_in;
         crc_ff    <= crc_in;
      end
   end

endmodule

[rtl/core/cccd_queue.sv]
// ----------------------------------------------------------------------------
// cccd_queue
// Small FIFO of classified entries between the parser and the result stage.
// ----------------------------------------------------------------------------
module cccd_queue #(
   parameter int DEPTH = cccd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   input  cccd_pkg::entry_type push_entry,
   output logic                full,
   output logic                pop_valid,
   input  logic                pop_ready,
   output cccd_pkg::entry_type pop_entry
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   cccd_pkg::entry_type mem_ff [DEPTH];
   logic [PW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]       count_ff, count_in;
   logic                do_push;
   logic                do_pop;

   assign full      = (count_ff == CW'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_entry = mem_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop_valid && pop_ready;

   // Advance pointers with wrap and track fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store entry
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

[rtl/core/cccd_back.sv]
// ----------------------------------------------------------------------------
// cccd_back
// Result stage: forms the verdict status from the queued checks and holds
// each result in an output register until it is taken.
// ----------------------------------------------------------------------------
module cccd_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                pop_valid,
   output logic                pop_ready,
   input  cccd_pkg::entry_type pop_entry,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_kind,
   output logic [7:0]          rsp_payload_byte,
   output logic [7:0]          rsp_frame_seq,
   output logic [7:0]          rsp_frame_cmd,
   output logic [15:0]         rsp_frame_length,
   output logic [1:0]          rsp_status
);

   logic                 valid_ff;
   logic                 kind_ff;
   logic [7:0]           payload_ff;
   logic [7:0]           seq_ff;
   logic [7:0]           cmd_ff;
   logic [15:0]          length_ff;
   cccd_pkg::status_type status_ff, status_in;
   logic                 load;

   assign pop_ready = !valid_ff || rsp_ready;
   assign load      = pop_valid && pop_ready;

   // End byte check wins over the CRC check
   always_comb begin
      if (pop_entry.kind == cccd_pkg::KIND_PAYLOAD) begin
         status_in = cccd_pkg::STATUS_OK;
      end else if (!pop_entry.end_ok) begin
         status_in = cccd_pkg::STATUS_BAD_END;
      end else if (!pop_entry.crc_ok) begin
         status_in = cccd_pkg::STATUS_BAD_CRC;
      end else begin
         status_in = cccd_pkg::STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (pop_ready) begin
         valid_ff <= pop_valid;
      end
   end

   // Load output register
   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff    <= pop_entry.kind;
         payload_ff <= pop_entry.payload_byte;
         seq_ff     <= pop_entry.frame_seq;
         cmd_ff     <= pop_entry.frame_cmd;
         length_ff  <= pop_entry.frame_length;
         status_ff  <= status_in;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_kind         = kind_ff;
   assign rsp_payload_byte = payload_ff;
   assign rsp_frame_seq    = seq_ff;
   assign rsp_frame_cmd    = cmd_ff;
   assign rsp_frame_length = length_ff;
   assign rsp_status       = status_ff;

endmodule

[rtl/core/crc_checked_command_deframer.sv]
// ----------------------------------------------------------------------------
// crc_checked_command_deframer
// Byte-wide command frame deframer with CRC-16 check and payload pass-out.
// ----------------------------------------------------------------------------
// Takes one received byte per cycle while req_ready is high. The parser
// updates its phase and the CRC-16 (one unrolled byte step) in the cycle
// the request is accepted and pushes every payload byte or closing byte
// into a QUEUE_DEPTH-entry queue at that same edge. The output register
// loads the entry from the queue and holds it until it is taken. Requests
// keep flowing while a result is not taken; req_ready drops only while the
// queue is full. Configuration writes are taken every cycle and should be
// made between frames.
module crc_checked_command_deframer #(
   parameter int QUEUE_DEPTH = cccd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [7:0]                       req_rx_byte,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_kind,
   output logic [7:0]                       rsp_payload_byte,
   output logic [7:0]                       rsp_frame_seq,
   output logic [7:0]                       rsp_frame_cmd,
   output logic [15:0]                      rsp_frame_length,
   output logic [1:0]                       rsp_status,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [cccd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [cccd_pkg::CSR_DATA_W-1:0]  csr_data
);

   logic                queue_full;
   logic                push_valid;
   cccd_pkg::entry_type push_entry;
   logic                pop_valid;
   logic                pop_ready;
   cccd_pkg::entry_type pop_entry;

   cccd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .queue_full  (queue_full),
      .push_valid  (push_valid),
      .push_entry  (push_entry)
   );

   cccd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   cccd_back u_back (
      .clock            (clock),
      .reset            (reset),
      .pop_valid        (pop_valid),
      .pop_ready        (pop_ready),
      .pop_entry        (pop_entry),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_frame_seq    (rsp_frame_seq),
      .rsp_frame_cmd    (rsp_frame_cmd),
      .rsp_frame_length (rsp_frame_length),
      .rsp_status       (rsp_status)
   );

endmodule

[tb/crc_checked_command_deframer_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// crc_checked_command_deframer_tb
// Self-checking bench for the CRC-16 command frame deframer.
// ----------------------------------------------------------------------------
// Byte requests go in over the req channel and a local model of the parser
// predicts every payload byte and every end-of-frame verdict, but where a
// typed table row fixes it. A short table of frames covers zero length, CRC
// and closing-byte errors, their priority, a dropped oversize frame and start
// bytes inside a frame. Random frames follow under several register settings,
// with random gaps on the request side and random stalls on the result side.
// ----------------------------------------------------------------------------
module crc_checked_command_deframer_tb;

   localparam int          RUN_LIMIT    = 900000;
   localparam int          QUIET_CYCLES = 16;
   localparam int          PHASE_BYTES  = 200;
   localparam logic [1:0]  CSR_UNUSED   = 2'd3;

   typedef struct {
      cccd_pkg::kind_type   kind;
      logic [7:0]           payload_byte;
      logic [7:0]           seq;
      logic [7:0]           cmd;
      logic [15:0]          length;
      cccd_pkg::status_type status;
   } deframe_result_type;

   typedef struct {
      logic [15:0]          length;
      logic [7:0]           seq;
      logic [7:0]           cmd;
      bit                   bad_crc;
      bit                   bad_close;
      bit                   fill_open;
      bit                   typed;
      cccd_pkg::status_type want;
   } frame_spec_type;

   typedef struct {
      logic [7:0]  open_byte;
      logic [7:0]  close_byte;
      logic [15:0] max_len;
   } setting_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_rx_byte;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_kind;
   logic [7:0]  rsp_payload_byte;
   logic [7:0]  rsp_frame_seq;
   logic [7:0]  rsp_frame_cmd;
   logic [15:0] rsp_frame_length;
   logic [1:0]  rsp_status;
   logic        csr_valid;
   logic        csr_ready;
   logic [cccd_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [cccd_pkg::CSR_DATA_W-1:0]  csr_data;

   // Parser model state and its copy of the registers
   cccd_pkg::phase_type st_phase;
   logic [15:0] st_length;
   logic [7:0]  st_seq;
   logic [7:0]  st_cmd;
   logic [15:0] st_count;
   logic [15:0] st_rx_crc;
   logic [15:0] st_crc;
   logic [7:0]  cfg_open;
   logic [7:0]  cfg_close;
   logic [15:0] cfg_max_len;

   deframe_result_type   pending_results[$];
   bit                   table_status_set;
   cccd_pkg::status_type table_status;

   int  error_count;
   int  cycle_count;
   int  bytes_sent;
   int  stall_left;
   bit  req_calm;
   bit  rsp_calm;

   crc_checked_command_deframer dut (.*);

   always #5 clock = ~clock;

   // CRC-16, MSB first, one input bit per step
   function automatic logic [15:0] crc16_step(logic [15:0] crc, logic [7:0] b);
      logic [15:0] c;
      logic        fb;
      c = crc;
      for (int i = 7; i >= 0; i--) begin
         fb = c[15] ^ b[i];
         c = {c[14:0], 1'b0};
         if (fb) c = c ^ cccd_pkg::CRC_POLY;
      end
      return c;
   endfunction

   function automatic void push_result(cccd_pkg::kind_type kind, logic [7:0] pb,
                                       cccd_pkg::status_type status);
      deframe_result_type r;
      r.kind         = kind;
      r.payload_byte = pb;
      r.seq          = st_seq;
      r.cmd          = st_cmd;
      r.length       = st_length;
      r.status       = status;
      pending_results.push_back(r);
   endfunction

   // Advance the parser model by one accepted byte
   function automatic void deframe_byte(logic [7:0] b);
      cccd_pkg::status_type verdict;
      case (st_phase)
         cccd_pkg::PH_LEN_L: begin
            st_length = {8'h00, b};
            st_crc    = crc16_step(st_crc, b);
            st_phase  = cccd_pkg::PH_LEN_H;
         end
         cccd_pkg::PH_LEN_H: begin
            st_length = {b, st_length[7:0]};
            st_crc    = crc16_step(st_crc, b);
            st_phase  = (st_length > cfg_max_len) ? cccd_pkg::PH_IDLE : cccd_pkg::PH_SEQ;
         end
         cccd_pkg::PH_SEQ: begin
            st_seq   = b;
            st_crc   = crc16_step(st_crc, b);
            st_phase = cccd_pkg::PH_CMD;
         end
         cccd_pkg::PH_CMD: begin
            st_cmd   = b;
            st_crc   = crc16_step(st_crc, b);
            st_count = '0;
            st_phase = (st_length != 16'd0) ? cccd_pkg::PH_DATA : cccd_pkg::PH_CRC_L;
         end
         cccd_pkg::PH_DATA: begin
            st_crc   = crc16_step(st_crc, b);
            st_count = st_count + 16'd1;
            if (st_count >= st_length) st_phase = cccd_pkg::PH_CRC_L;
            push_result(cccd_pkg::KIND_PAYLOAD, b, cccd_pkg::STATUS_OK);
         end
         cccd_pkg::PH_CRC_L: begin
            st_rx_crc = {8'h00, b};
            st_phase  = cccd_pkg::PH_CRC_H;
         end
         cccd_pkg::PH_CRC_H: begin
            st_rx_crc = {b, st_rx_crc[7:0]};
            st_phase  = cccd_pkg::PH_END;
         end
         cccd_pkg::PH_END: begin
            // closing byte is judged before the CRC
            if (b != cfg_close)           verdict = cccd_pkg::STATUS_BAD_END;
            else if (st_crc != st_rx_crc) verdict = cccd_pkg::STATUS_BAD_CRC;
            else                          verdict = cccd_pkg::STATUS_OK;
            if (table_status_set) verdict = table_status;
            st_phase = cccd_pkg::PH_IDLE;
            push_result(cccd_pkg::KIND_VERDICT, 8'h00, verdict);
         end
         default: begin
            st_phase = cccd_pkg::PH_IDLE;
            if (b == cfg_open) begin
               st_crc   = cccd_pkg::CRC_INIT;
               st_phase = cccd_pkg::PH_LEN_L;
            end
         end
      endcase
   endfunction

   task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
      error_count++;
      $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
   endtask

   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 1;
      if (r < 85) return $urandom_range(2, 4);
      if (r < 97) return $urandom_range(5, 12);
      return $urandom_range(20, 60);
   endfunction

   // Cycle count, watchdog and calm stretches on both sides
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count % 300 == 0) begin
         req_calm <= ($urandom_range(0, 3) == 0);
         rsp_calm <= ($urandom_range(0, 3) == 0);
      end
      if (cycle_count > RUN_LIMIT) begin
         $display("crc_checked_command_deframer_tb: errors");
         $finish;
      end
   end

   // Result side: random stalls, compare each result with the oldest prediction
   always @(posedge clock) begin
      deframe_result_type exp_r;
      if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_ready <= 1'b0;
      end else if (!rsp_calm && $urandom_range(0, 99) < 25) begin
         stall_left = idle_length() - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result", 16'(rsp_payload_byte), 16'h0);
         end else begin
            exp_r = pending_results.pop_front();
            if (rsp_kind !== exp_r.kind)
               report_mismatch("kind", 16'(rsp_kind), 16'(exp_r.kind));
            if (rsp_payload_byte !== exp_r.payload_byte)
               report_mismatch("payload_byte", 16'(rsp_payload_byte),
                               16'(exp_r.payload_byte));
            if (rsp_frame_seq !== exp_r.seq)
               report_mismatch("frame_seq", 16'(rsp_frame_seq), 16'(exp_r.seq));
            if (rsp_frame_cmd !== exp_r.cmd)
               report_mismatch("frame_cmd", 16'(rsp_frame_cmd), 16'(exp_r.cmd));
            if (rsp_frame_length !== exp_r.length)
               report_mismatch("frame_length", rsp_frame_length, exp_r.length);
            if (rsp_status !== exp_r.status)
               report_mismatch("status", 16'(rsp_status), 16'(exp_r.status));
         end
      end
   end

   // Hand one byte request to the block, then sometimes idle for a random gap
   task automatic send_byte(logic [7:0] b);
      int gap;
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (!req_ready);
      deframe_byte(b);
      bytes_sent++;
      gap = (!req_calm && $urandom_range(0, 99) < 35) ? idle_length() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_noise();
      logic [7:0] b;
      b = 8'($urandom_range(0, 255));
      if (b == cfg_open) b = b ^ 8'h01;
      send_byte(b);
   endtask

   // Build one frame; an oversize frame stops after its length bytes
   task automatic send_frame(logic [15:0] length, logic [7:0] seq, logic [7:0] cmd,
                             bit bad_crc, bit bad_close, bit fill_open);
      logic [7:0]  frame_q[$];
      logic [15:0] crc;
      logic [7:0]  b;
      frame_q = '{cfg_open, length[7:0], length[15:8], seq, cmd};
      if (length > cfg_max_len) begin
         foreach (frame_q[i]) if (i < 3) send_byte(frame_q[i]);
         return;
      end
      for (int i = 0; i < length; i++) begin
         b = (fill_open || $urandom_range(0, 9) == 0) ? cfg_open : 8'($urandom_range(0, 255));
         frame_q.push_back(b);
      end
      crc = cccd_pkg::CRC_INIT;
      for (int i = 1; i < frame_q.size(); i++) crc = crc16_step(crc, frame_q[i]);
      if (bad_crc) crc = crc ^ 16'($urandom_range(1, 65535));
      frame_q.push_back(crc[7:0]);
      frame_q.push_back(crc[15:8]);
      frame_q.push_back(bad_close ? cfg_close ^ 8'($urandom_range(1, 255)) : cfg_close);
      foreach (frame_q[i]) send_byte(frame_q[i]);
   endtask

   function automatic logic [15:0] pick_length();
      int r;
      int cap;
      cap = int'(cfg_max_len);
      r = $urandom_range(0, 99);
      if (r < 80) return 16'($urandom_range(0, (cap < 12) ? cap : 12));
      if (r < 93) return 16'($urandom_range(0, (cap < 40) ? cap : 40));
      if (r < 98 && cap <= 64) return 16'(cap);
      return 16'($urandom_range(0, (cap < 300) ? cap : 300));
   endfunction

   // Finish any open frame, then wait until every result has been taken
   task automatic settle();
      while (st_phase != cccd_pkg::PH_IDLE) send_noise();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         cccd_pkg::CSR_START_BYTE: cfg_open    = data[7:0];
         cccd_pkg::CSR_END_BYTE:   cfg_close   = data[7:0];
         cccd_pkg::CSR_MAX_LENGTH: cfg_max_len = data;
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   frame_spec_type directed_frames [6] = '{
      '{16'd0,   8'h00, 8'hFF, 1'b0, 1'b0, 1'b0, 1'b1, cccd_pkg::STATUS_OK},
      '{16'd1,   8'hFF, 8'h00, 1'b1, 1'b0, 1'b0, 1'b1, cccd_pkg::STATUS_BAD_CRC},
      '{16'd2,   8'hAA, 8'hAA, 1'b0, 1'b1, 1'b1, 1'b1, cccd_pkg::STATUS_BAD_END},
      '{16'd1,   8'h5A, 8'hA5, 1'b1, 1'b1, 1'b0, 1'b1, cccd_pkg::STATUS_BAD_END},
      '{16'd257, 8'h11, 8'h22, 1'b0, 1'b0, 1'b0, 1'b0, cccd_pkg::STATUS_OK},
      '{16'd3,   8'h33, 8'h44, 1'b0, 1'b0, 1'b0, 1'b0, cccd_pkg::STATUS_OK}
   };

   setting_type settings [6] = '{
      '{8'h00, 8'hFF, 16'd0},
      '{8'hFF, 8'h00, 16'hFFFF},
      '{8'h7E, 8'h7E, 16'd1},
      '{8'h00, 8'h00, 16'd8},
      '{8'h00, 8'h00, 16'd40},
      '{cccd_pkg::START_BYTE_RESET, cccd_pkg::END_BYTE_RESET, cccd_pkg::MAX_LENGTH_RESET}
   };

   initial begin
      int          r;
      int          phase_start;
      setting_type s;
      clock       = 1'b0;
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_rx_byte <= 8'h00;
      csr_valid   <= 1'b0;
      csr_index   <= cccd_pkg::CSR_START_BYTE;
      csr_data    <= '0;
      bytes_sent  = 0;
      table_status_set = 1'b0;
      table_status     = cccd_pkg::STATUS_OK;
      st_phase    = cccd_pkg::PH_IDLE;
      st_length   = '0;
      st_seq      = '0;
      st_cmd      = '0;
      st_count    = '0;
      st_rx_crc   = '0;
      st_crc      = cccd_pkg::CRC_INIT;
      cfg_open    = cccd_pkg::START_BYTE_RESET;
      cfg_close   = cccd_pkg::END_BYTE_RESET;
      cfg_max_len = cccd_pkg::MAX_LENGTH_RESET;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: idle noise, then the frame table under reset settings
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(cccd_pkg::END_BYTE_RESET);
      foreach (directed_frames[i]) begin
         table_status_set = directed_frames[i].typed;
         table_status     = directed_frames[i].want;
         send_frame(directed_frames[i].length, directed_frames[i].seq,
                    directed_frames[i].cmd, directed_frames[i].bad_crc,
                    directed_frames[i].bad_close, directed_frames[i].fill_open);
         table_status_set = 1'b0;
      end
      settle();

      // Random frames under each register setting
      foreach (settings[p]) begin
         s = settings[p];
         if (p == 3 || p == 4) begin
            s.open_byte  = 8'($urandom_range(0, 255));
            s.close_byte = 8'($urandom_range(0, 255));
         end
         write_csr(cccd_pkg::CSR_START_BYTE, {8'($urandom_range(0, 255)), s.open_byte});
         write_csr(cccd_pkg::CSR_END_BYTE, {8'($urandom_range(0, 255)), s.close_byte});
         write_csr(cccd_pkg::CSR_MAX_LENGTH, s.max_len);
         write_csr(CSR_UNUSED, 16'($urandom_range(0, 65535)));
         phase_start = bytes_sent;
         while (bytes_sent - phase_start < PHASE_BYTES) begin
            r = $urandom_range(0, 99);
            if (r < 75)
               send_frame(pick_length(), 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)), $urandom_range(0, 99) < 12,
                          $urandom_range(0, 99) < 8, $urandom_range(0, 99) < 4);
            else if (r < 88 && cfg_max_len != 16'hFFFF)
               send_frame(16'($urandom_range(int'(cfg_max_len) + 1, 65535)),
                          8'h00, 8'h00, 1'b0, 1'b0, 1'b0);
            else
               repeat ($urandom_range(1, 4)) send_noise();
         end
         settle();
      end

      if (error_count == 0)
         $display("crc_checked_command_deframer_tb: clean");
      else
         $display("crc_checked_command_deframer_tb: errors");
      $finish;
   end

endmodule
